[rtl/led_blink_status_decoder_core_assert.svh]
// ---------------------------------------------------------------------------
// LED blink status decoder assertion macros
// Shared macros for the concurrent checks of the decoder core.
// ---------------------------------------------------------------------------
`ifndef LED_BLINK_STATUS_DECODER_CORE_ASSERT_SVH
`define LED_BLINK_STATUS_DECODER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LBSD_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LBSD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/lbsd_pkg.sv]
// ---------------------------------------------------------------------------
// LED blink status decoder package
// Shared types and constants for the decoder core and its channels.
// ---------------------------------------------------------------------------
package lbsd_pkg;

    localparam int NUM_LEDS     = 3;
    localparam int CNT_W        = 4;
    localparam int CLASS_W      = 2;
    localparam int STATUS_W     = 3;

    localparam logic [CNT_W-1:0] SETTLE_RESET = 4'd8;

    typedef logic [CNT_W-1:0] cnt_t;

    typedef enum logic [CLASS_W-1:0] {
        CLS_OFF   = 2'd0,
        CLS_ON    = 2'd1,
        CLS_BLINK = 2'd2
    } class_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_POWER_OFF = 3'd0,
        ST_POWER_ON  = 3'd1,
        ST_BUSY      = 3'd2,
        ST_NO_PAPER  = 3'd3,
        ST_PAPER_JAM = 3'd4,
        ST_ERROR     = 3'd5
    } status_t;

    typedef struct packed {
        logic fire;
        logic level;
    } lane_ctl_t;

endpackage

[rtl/lbsd_channels.sv]
// ---------------------------------------------------------------------------
// LED blink status decoder channels
// Valid/ready interfaces for the LED sample, result and settle write words.
// ---------------------------------------------------------------------------
interface lbsd_pins_if;
    logic valid;
    logic ready;
    logic led_pwr;
    logic led_paper;
    logic led_ink;

    modport source (output valid, output led_pwr, output led_paper, output led_ink,
                    input ready);
    modport sink (input valid, input led_pwr, input led_paper, input led_ink,
                  output ready);
endinterface

interface lbsd_result_if;
    import lbsd_pkg::*;
    logic                valid;
    logic                ready;
    logic [CLASS_W-1:0]  pwr_class;
    logic [CLASS_W-1:0]  paper_class;
    logic [CLASS_W-1:0]  ink_class;
    logic [STATUS_W-1:0] printer_status;

    modport source (output valid, output pwr_class, output paper_class,
                    output ink_class, output printer_status, input ready);
    modport sink (input valid, input pwr_class, input paper_class,
                  input ink_class, input printer_status, output ready);
endinterface

interface lbsd_cfg_if;
    import lbsd_pkg::*;
    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[rtl/led_blink_status_decoder_core.sv]
// ---------------------------------------------------------------------------
// LED blink status decoder core
// Classes three status LEDs from their tick levels and decodes printer status.
// ---------------------------------------------------------------------------
// An accepted sample word is registered as its result word in the cycle after it.
// One word per cycle unless a held result word is not taken; the three LED lanes
// and the pattern match are combinational, and the output register takes a new
// word while the previous one is read out.
// Reset: rst_n clears all counters, the status to power off and the settle
// threshold to eight.
module led_blink_status_decoder_core (
    input  logic          clk,
    input  logic          rst_n,
    lbsd_pins_if.sink     pins,
    lbsd_result_if.source result,
    lbsd_cfg_if.sink      cfg
);
    import lbsd_pkg::*;

    cnt_t      settle_reg;
    cnt_t      settle_next;
    logic      fire;
    logic      can_take;
    logic      lvl [NUM_LEDS];
    lane_ctl_t ctl [NUM_LEDS];
    class_t    cls [NUM_LEDS];
    class_t    out_cls [NUM_LEDS];
    status_t   out_status;

    assign cfg.ready   = 1'b1;
    assign settle_next = (cfg.valid && cfg.ready) ? cfg.data : settle_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            settle_reg <= SETTLE_RESET;
        else
            settle_reg <= settle_next;
    end

    assign pins.ready = can_take;
    assign fire       = pins.valid && can_take;

    assign lvl[0] = pins.led_pwr;
    assign lvl[1] = pins.led_paper;
    assign lvl[2] = pins.led_ink;

    for (genvar g = 0; g < NUM_LEDS; g++)
    begin : g_lane
        assign ctl[g].fire  = fire;
        assign ctl[g].level = lvl[g];

        lbsd_lane u_lane (
            .clk    (clk),
            .rst_n  (rst_n),
            .settle (settle_reg),
            .ctl    (ctl[g]),
            .cls    (cls[g])
        );
    end

    lbsd_merge u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (fire),
        .cls        (cls),
        .out_ready  (result.ready),
        .can_take   (can_take),
        .out_valid  (result.valid),
        .out_cls    (out_cls),
        .out_status (out_status)
    );

    assign result.pwr_class      = CLASS_W'(out_cls[0]);
    assign result.paper_class    = CLASS_W'(out_cls[1]);
    assign result.ink_class      = CLASS_W'(out_cls[2]);
    assign result.printer_status = STATUS_W'(out_status);

endmodule

[rtl/lbsd_lane.sv]
// ---------------------------------------------------------------------------
// LED blink status decoder lane
// Lit and dark tick counters of one LED and its steady or blinking class.
// ---------------------------------------------------------------------------
module lbsd_lane (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [3:0]         settle,
    input  lbsd_pkg::lane_ctl_t ctl,
    output lbsd_pkg::class_t   cls
);
    import lbsd_pkg::*;

    cnt_t lit_reg;
    cnt_t lit_next;
    cnt_t dark_reg;
    cnt_t dark_next;

    always_comb
    begin
        lit_next  = lit_reg;
        dark_next = dark_reg;
        cls       = CLS_OFF;
        if (ctl.level)
        begin
            if (lit_reg < settle)
            begin
                lit_next = lit_reg + cnt_t'(1);
                cls      = CLS_BLINK;
            end
            else
            begin
                cls = CLS_ON;
            end
            dark_next = '0;
        end
        else
        begin
            if (dark_reg < settle)
            begin
                dark_next = dark_reg + cnt_t'(1);
                cls       = CLS_BLINK;
            end
            else
            begin
                cls = CLS_OFF;
            end
            lit_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lit_reg  <= '0;
            dark_reg <= '0;
        end
        else if (ctl.fire)
        begin
            lit_reg  <= lit_next;
            dark_reg <= dark_next;
        end
    end

endmodule

[rtl/lbsd_merge.sv]
// ---------------------------------------------------------------------------
// LED blink status decoder merge stage
// Matches the lane classes against the status patterns and holds the result.
// ---------------------------------------------------------------------------
module lbsd_merge (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  lbsd_pkg::class_t cls [lbsd_pkg::NUM_LEDS],
    input  logic             out_ready,
    output logic             can_take,
    output logic             out_valid,
    output lbsd_pkg::class_t out_cls [lbsd_pkg::NUM_LEDS],
    output lbsd_pkg::status_t out_status
);
    import lbsd_pkg::*;

    status_t status_reg;
    status_t status_next;
    logic    valid_reg;
    logic    valid_next;
    class_t  cls_reg [NUM_LEDS];

    function automatic logic match3(input class_t a, input class_t b, input class_t c,
                                    input class_t x0, input class_t x1,
                                    input class_t x2);
        return (a == x0) && (b == x1) && (c == x2);
    endfunction

    always_comb
    begin
        status_next = status_reg;
        if (match3(cls[0], cls[1], cls[2], CLS_OFF, CLS_OFF, CLS_OFF))
            status_next = ST_POWER_OFF;
        else if (match3(cls[0], cls[1], cls[2], CLS_ON, CLS_OFF, CLS_OFF))
            status_next = ST_POWER_ON;
        else if (match3(cls[0], cls[1], cls[2], CLS_BLINK, CLS_OFF, CLS_OFF))
            status_next = ST_BUSY;
        else if (match3(cls[0], cls[1], cls[2], CLS_BLINK, CLS_ON, CLS_OFF))
            status_next = ST_NO_PAPER;
        else if (match3(cls[0], cls[1], cls[2], CLS_BLINK, CLS_BLINK, CLS_OFF))
            status_next = ST_PAPER_JAM;
        else if (match3(cls[0], cls[1], cls[2], CLS_OFF, CLS_BLINK, CLS_BLINK))
            status_next = ST_ERROR;
    end

    assign can_take = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (fire)
            valid_next = 1'b1;
        else if (out_ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_reg <= ST_POWER_OFF;
            valid_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (fire)
                status_reg <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
            cls_reg <= cls;
    end

    assign out_valid  = valid_reg;
    assign out_cls    = cls_reg;
    assign out_status = status_reg;

endmodule

[rtl/lbsd_checker.sv]
// ---------------------------------------------------------------------------
// LED blink status decoder checker
// Port-level checks of the decoder core, bound to the top level.
// ---------------------------------------------------------------------------
`include "led_blink_status_decoder_core_assert.svh"

module lbsd_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       res_valid,
    input logic       res_ready,
    input logic [1:0] pwr_class,
    input logic [1:0] paper_class,
    input logic [1:0] ink_class,
    input logic [2:0] printer_status
);
    import lbsd_pkg::*;

    `LBSD_ASSERT_NEXT(a_res_hold, clk, rst_n, res_valid && !res_ready, res_valid, "result word dropped while stalled")
    `LBSD_ASSERT_NEXT(a_word_out, clk, rst_n, in_valid && in_ready, res_valid, "accepted word produced no result")
    `LBSD_ASSERT_NOW(a_codes, clk, rst_n, res_valid, (pwr_class != 2'd3) && (paper_class != 2'd3) && (ink_class != 2'd3) && (printer_status <= 3'(ST_ERROR)), "illegal class or status code")
    `LBSD_ASSERT_NOW(a_all_off, clk, rst_n, res_valid && (pwr_class == 2'(CLS_OFF)) && (paper_class == 2'(CLS_OFF)) && (ink_class == 2'(CLS_OFF)), printer_status == 3'(ST_POWER_OFF), "all LEDs off but status not power off")

endmodule

bind led_blink_status_decoder_core lbsd_checker u_lbsd_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (pins.valid),
    .in_ready       (pins.ready),
    .res_valid      (result.valid),
    .res_ready      (result.ready),
    .pwr_class      (result.pwr_class),
    .paper_class    (result.paper_class),
    .ink_class      (result.ink_class),
    .printer_status (result.printer_status)
);

[test/led_blink_status_decoder_core_test.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// LED blink status decoder core testbench
// Drives LED sample words through the valid/ready channels with random
// bursts and stalls, rewrites the settle threshold between phases, and checks
// every result word against a planned expectation or an in-bench model of
// the LED classing and printer status decode.
// ---------------------------------------------------------------------------
module led_blink_status_decoder_core_test;
    import lbsd_pkg::*;

    typedef struct packed {
        class_t  pwr;
        class_t  paper;
        class_t  ink;
        status_t status;
    } report_t;

    typedef struct packed {
        bit      known;
        report_t want;
    } sent_tick_t;

    typedef struct packed {
        bit       is_settle;
        cnt_t     settle;
        logic [2:0] levels;
        bit       known;
        report_t  want;
    } plan_row_t;

    logic clk = 1'b0;
    logic rst_n;

    lbsd_pins_if   pins();
    lbsd_result_if result();
    lbsd_cfg_if    cfg();

    led_blink_status_decoder_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .pins   (pins),
        .result (result),
        .cfg    (cfg)
    );

    cnt_t    settle_now = SETTLE_RESET;
    cnt_t    lit_cnt [NUM_LEDS] = '{default: '0};
    cnt_t    dark_cnt [NUM_LEDS] = '{default: '0};
    class_t  led_cls [NUM_LEDS] = '{default: CLS_OFF};
    status_t held_status = ST_POWER_OFF;

    report_t    status_due_q [$];
    sent_tick_t sent_tick_q [$];
    plan_row_t  tick_plan [$];
    int         mismatch_count = 0;
    int         burst_left = 1;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic report_t decode_tick(input logic [2:0] levels);
        report_t r;
        for (int k = 0; k < NUM_LEDS; k++)
        begin
            if (levels[2-k])
            begin
                if (lit_cnt[k] < settle_now)
                begin
                    lit_cnt[k] = lit_cnt[k] + 1'b1;
                    led_cls[k] = CLS_BLINK;
                end
                else
                    led_cls[k] = CLS_ON;
                dark_cnt[k] = '0;
            end
            else
            begin
                if (dark_cnt[k] < settle_now)
                begin
                    dark_cnt[k] = dark_cnt[k] + 1'b1;
                    led_cls[k] = CLS_BLINK;
                end
                else
                    led_cls[k] = CLS_OFF;
                lit_cnt[k] = '0;
            end
        end
        if (led_cls[0] == CLS_OFF && led_cls[1] == CLS_OFF && led_cls[2] == CLS_OFF)
            held_status = ST_POWER_OFF;
        else if (led_cls[0] == CLS_ON && led_cls[1] == CLS_OFF && led_cls[2] == CLS_OFF)
            held_status = ST_POWER_ON;
        else if (led_cls[0] == CLS_BLINK && led_cls[1] == CLS_OFF && led_cls[2] == CLS_OFF)
            held_status = ST_BUSY;
        else if (led_cls[0] == CLS_BLINK && led_cls[1] == CLS_ON && led_cls[2] == CLS_OFF)
            held_status = ST_NO_PAPER;
        else if (led_cls[0] == CLS_BLINK && led_cls[1] == CLS_BLINK
                 && led_cls[2] == CLS_OFF)
            held_status = ST_PAPER_JAM;
        else if (led_cls[0] == CLS_OFF && led_cls[1] == CLS_BLINK
                 && led_cls[2] == CLS_BLINK)
            held_status = ST_ERROR;
        r.pwr    = led_cls[0];
        r.paper  = led_cls[1];
        r.ink    = led_cls[2];
        r.status = held_status;
        return r;
    endfunction

    always @(posedge clk)
    begin
        report_t    got_want;
        sent_tick_t tick;
        report_t    predicted;
        if (rst_n)
        begin
            if (result.valid && result.ready)
            begin
                if (status_due_q.size() == 0)
                begin
                    $error("result word with no expectation waiting");
                    mismatch_count++;
                end
                else
                begin
                    got_want = status_due_q.pop_front();
                    if (result.pwr_class !== got_want.pwr)
                    begin
                        $error("pwr_class: expected %0d, actual %0d",
                               got_want.pwr, result.pwr_class);
                        mismatch_count++;
                    end
                    if (result.paper_class !== got_want.paper)
                    begin
                        $error("paper_class: expected %0d, actual %0d",
                               got_want.paper, result.paper_class);
                        mismatch_count++;
                    end
                    if (result.ink_class !== got_want.ink)
                    begin
                        $error("ink_class: expected %0d, actual %0d",
                               got_want.ink, result.ink_class);
                        mismatch_count++;
                    end
                    if (result.printer_status !== got_want.status)
                    begin
                        $error("printer_status: expected %0d, actual %0d",
                               got_want.status, result.printer_status);
                        mismatch_count++;
                    end
                end
            end
            if (pins.valid && pins.ready)
            begin
                predicted = decode_tick({pins.led_pwr, pins.led_paper, pins.led_ink});
                tick = sent_tick_q.pop_front();
                status_due_q.push_back(tick.known ? tick.want : predicted);
            end
            if (cfg.valid && cfg.ready)
                settle_now = cfg.data;
        end
    end

    task automatic send_word(input logic [2:0] levels, input bit known, input report_t want);
        int gap;
        sent_tick_q.push_back('{known, want});
        pins.valid     <= 1'b1;
        pins.led_pwr   <= levels[2];
        pins.led_paper <= levels[1];
        pins.led_ink   <= levels[0];
        @(posedge clk);
        while (!pins.ready)
            @(posedge clk);
        burst_left--;
        if (burst_left <= 0)
        begin
            gap = $urandom_range(0, 6);
            if (gap > 0)
            begin
                pins.valid     <= 1'b0;
                pins.led_pwr   <= 1'($urandom_range(0, 1));
                pins.led_paper <= 1'($urandom_range(0, 1));
                pins.led_ink   <= 1'($urandom_range(0, 1));
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 20);
        end
    endtask

    task automatic wait_drained();
        pins.valid <= 1'b0;
        @(posedge clk);
        while (status_due_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_settle(input cnt_t value);
        wait_drained();
        cfg.valid <= 1'b1;
        cfg.data  <= value;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        cfg.valid <= 1'b0;
    endtask

    task automatic plan_word(input logic [2:0] levels);
        tick_plan.push_back('{1'b0, '0, levels, 1'b0, '0});
    endtask

    task automatic plan_known(input logic [2:0] levels, input report_t want);
        tick_plan.push_back('{1'b0, '0, levels, 1'b1, want});
    endtask

    task automatic plan_settle(input cnt_t value);
        tick_plan.push_back('{1'b1, value, 3'b000, 1'b0, '0});
    endtask

    task automatic random_phase(input int count);
        int sent;
        int len;
        int mode [NUM_LEDS];
        logic [2:0] levels;
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                len = $urandom_range(1, 4);
                for (int t = 0; t < len; t++)
                    send_word(3'($urandom_range(0, 7)), 1'b0, '0);
            end
            else
            begin
                len = $urandom_range(1, int'(settle_now) + 6);
                for (int k = 0; k < NUM_LEDS; k++)
                begin
                    mode[k] = $urandom_range(0, 5);
                    levels[2-k] = (mode[k] >= 2 && mode[k] <= 3) ? 1'b1
                                : (mode[k] <= 1) ? 1'b0 : 1'($urandom_range(0, 1));
                end
                for (int t = 0; t < len; t++)
                begin
                    send_word(levels, 1'b0, '0);
                    for (int k = 0; k < NUM_LEDS; k++)
                    begin
                        if (mode[k] == 4)
                            levels[2-k] = ~levels[2-k];
                        else if (mode[k] == 5)
                            levels[2-k] = 1'($urandom_range(0, 1));
                    end
                end
            end
            sent += len;
        end
    endtask

    initial
    begin
        int          total;
        int          phase;
        cnt_t        next_settle;
        pins.valid     = 1'b0;
        pins.led_pwr   = 1'b0;
        pins.led_paper = 1'b0;
        pins.led_ink   = 1'b0;
        cfg.valid      = 1'b0;
        cfg.data       = '0;
        rst_n          = 1'b0;
        burst_left     = $urandom_range(1, 20);

        plan_known(3'b000, '{CLS_BLINK, CLS_BLINK, CLS_BLINK, ST_POWER_OFF});
        plan_settle(4'd1);
        plan_known(3'b000, '{CLS_OFF, CLS_OFF, CLS_OFF, ST_POWER_OFF});
        plan_known(3'b100, '{CLS_BLINK, CLS_OFF, CLS_OFF, ST_BUSY});
        plan_known(3'b100, '{CLS_ON, CLS_OFF, CLS_OFF, ST_POWER_ON});
        plan_known(3'b110, '{CLS_ON, CLS_BLINK, CLS_OFF, ST_POWER_ON});
        plan_word(3'b110);
        plan_known(3'b010, '{CLS_BLINK, CLS_ON, CLS_OFF, ST_NO_PAPER});
        plan_word(3'b000);
        plan_known(3'b110, '{CLS_BLINK, CLS_BLINK, CLS_OFF, ST_PAPER_JAM});
        plan_word(3'b011);
        plan_known(3'b000, '{CLS_OFF, CLS_BLINK, CLS_BLINK, ST_ERROR});
        plan_word(3'b000);
        plan_settle(4'd0);
        plan_known(3'b111, '{CLS_ON, CLS_ON, CLS_ON, ST_POWER_OFF});
        plan_word(3'b101);
        plan_known(3'b000, '{CLS_OFF, CLS_OFF, CLS_OFF, ST_POWER_OFF});
        plan_settle(4'd15);
        plan_word(3'b111);
        plan_word(3'b010);

        repeat (8) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;
        @(posedge clk);

        foreach (tick_plan[i])
        begin
            if (tick_plan[i].is_settle)
                write_settle(tick_plan[i].settle);
            else
                send_word(tick_plan[i].levels, tick_plan[i].known, tick_plan[i].want);
        end

        total = 0;
        phase = 0;
        while (total < 1600)
        begin
            case (phase)
                0: next_settle = 4'd15;
                1: next_settle = 4'd0;
                2: next_settle = 4'd1;
                3: next_settle = SETTLE_RESET;
                default: next_settle = cnt_t'($urandom_range(0, 15));
            endcase
            write_settle(next_settle);
            random_phase($urandom_range(60, 220));
            total = total + 140;
            phase++;
        end

        wait_drained();
        repeat (4) @(posedge clk);
        if (mismatch_count == 0 && status_due_q.size() == 0)
            $display("led_blink_status_decoder_core verification clean");
        else
            $display("led_blink_status_decoder_core verification failed");
        $finish;
    end

    initial
    begin
        int mode;
        int span;
        int beat;
        result.ready = 1'b0;
        beat = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(8, 64);
            repeat (span)
            begin
                @(posedge clk);
                case (mode)
                    0: result.ready <= 1'b1;
                    1: result.ready <= 1'($urandom_range(0, 1));
                    2: result.ready <= (beat % 3 == 0);
                    default: result.ready <= ($urandom_range(0, 3) == 0);
                endcase
                beat++;
            end
        end
    end

    initial
    begin
        #2000000;
        $display("led_blink_status_decoder_core verification failed");
        $finish;
    end

endmodule
